/* rtl/core/diff_drive_odometry_sequencer_core_assert.svh */
// Assertion macros for the odometry sequencer core.
`ifndef DIFF_DRIVE_ODOMETRY_SEQUENCER_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_SEQUENCER_CORE_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define DDO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property also during reset.
`define DDO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

/* rtl/core/ddo_pkg.sv */
// Package with constants, types and helper functions of the odometry core.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;
  localparam int CordicSteps = 16;
  localparam int FracBits    = 16;
  localparam int StepW       = $clog2(CordicSteps + 1);
  // Quotient bits of |heading + d/2| in Q2.30 over 2*pi: the sum stays below
  // 3 * 2^(30+30-FracBits), which is under 2*pi * 2^RedSteps.
  localparam int RedSteps    = 13;

  localparam logic [1:0] MoveStop    = 2'd0;
  localparam logic [1:0] MoveForward = 2'd1;
  localparam logic [1:0] MoveTurn    = 2'd2;

  localparam logic [2:0] CfgMpt   = 3'd0;
  localparam logic [2:0] CfgInvTr = 3'd1;
  localparam logic [2:0] CfgShort = 3'd2;
  localparam logic [2:0] CfgLong  = 3'd3;
  localparam logic [2:0] CfgTurn  = 3'd4;
  localparam logic [2:0] CfgLimit = 3'd5;

  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  typedef struct packed {
    logic       start;
    logic       run;
    logic [StepW-1:0] step;
  } cordic_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] atan_q30(input logic [StepW-1:0] i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i > 30) ? 34'sd0 : (34'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ddo_cordic.sv */
// Iterative CORDIC rotation unit, one micro-rotation per cycle while run is set.
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ddo_pkg::cordic_ctl_t ctl_i,
  input  wire logic signed [35:0]   z_i,
  output logic signed [33:0]        cos_o,
  output logic signed [33:0]        sin_o
);
  logic signed [33:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic signed [33:0] xs, ys, at;

  assign xs = x_q >>> ctl_i.step;
  assign ys = y_q >>> ctl_i.step;
  assign at = ddo_pkg::atan_q30(ctl_i.step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (ctl_i.start) begin
      x_q <= ddo_pkg::GainQ30;
      y_q <= '0;
      z_q <= z_i;
    end else if (ctl_i.run) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - 36'(at);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + 36'(at);
      end
    end
  end

  assign cos_o = x_q;
  assign sin_o = y_q;
endmodule
`default_nettype wire

/* rtl/core/diff_drive_odometry_sequencer_core.sv */
// Top level of the differential-drive odometry and edge sequencer core.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat carries cumulative right and left encoder counts; the core
// returns one result beat with the move code (stop, forward, turn left), the
// Q16.16 pose and unwrapped heading, the saturating edge count and the
// distance along the current edge. After the input beat is accepted, the
// states run in order: StRight, StLeft and StHead, in which one 34x34
// multiplier forms the wheel steps and the heading change; StRed, RedSteps (13)
// steps of compare and subtract that bring the mid-step heading into range
// modulo 2*pi; StLoad to load the CORDIC unit; StRot for the CordicSteps
// rotations; and StPosX and StPosY for the position products on the same
// multiplier. The core takes no new beat until the result beat has been
// taken and it is back in idle.
module diff_drive_odometry_sequencer_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] right_ticks_i,
  input  wire logic signed [31:0] left_ticks_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              move_code_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      heading_out_o,
  output logic [3:0]              edges_done_o,
  output logic [30:0]             edge_progress_o
);
`include "diff_drive_odometry_sequencer_core_assert.svh"
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRight = 4'd1;
  localparam logic [3:0] StLeft  = 4'd2;
  localparam logic [3:0] StHead  = 4'd3;
  localparam logic [3:0] StRed   = 4'd4;
  localparam logic [3:0] StLoad  = 4'd5;
  localparam logic [3:0] StRot   = 4'd6;
  localparam logic [3:0] StPosX  = 4'd7;
  localparam logic [3:0] StPosY  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  // Configuration registers.
  logic [23:0] mpt_q;
  logic [15:0] inv_tr_q;
  logic [30:0] short_q, long_q, turn_ang_q;
  logic [3:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q      <= 24'd899079;
      inv_tr_q   <= 16'd6400;
      short_q    <= 31'd39951;
      long_q     <= 31'd59927;
      turn_ang_q <= 31'd65536;
      limit_q    <= 4'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ddo_pkg::CfgMpt:   mpt_q      <= cfg_data_i[23:0];
        ddo_pkg::CfgInvTr: inv_tr_q   <= cfg_data_i[15:0];
        ddo_pkg::CfgShort: short_q    <= cfg_data_i;
        ddo_pkg::CfgLong:  long_q     <= cfg_data_i;
        ddo_pkg::CfgTurn:  turn_ang_q <= cfg_data_i;
        ddo_pkg::CfgLimit: limit_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0] state_q;
  logic [ddo_pkg::StepW-1:0] step_q;
  logic signed [31:0] last_r_q, last_l_q, px_q, py_q, hd_q, ed_q, tt_q;
  logic turning_q, short_next_q;
  logic [3:0] cnt_q;
  logic [1:0] move_q;
  logic signed [31:0] in_r_q, in_l_q, rs_q, ls_q, d_q;
  logic signed [32:0] s_q;

  // Shared multiplier: signed 34 x 34, operands picked by state.
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [33:0] cos_w, sin_w;
  logic signed [31:0] rdiff, ldiff;
  logic signed [32:0] dsum;

  assign rdiff = in_r_q - last_r_q;
  assign ldiff = in_l_q - last_l_q;
  assign dsum  = 33'(rs_q) - 33'(ls_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      StRight: begin ma = 34'(rdiff); mb = 34'($signed({1'b0, mpt_q})); end
      StLeft:  begin ma = 34'(ldiff); mb = 34'($signed({1'b0, mpt_q})); end
      StHead:  begin ma = 34'(dsum);  mb = 34'($signed({1'b0, inv_tr_q})); end
      StPosX:  begin ma = cos_w; mb = 34'(s_q); end
      StPosY:  begin ma = sin_w; mb = 34'(s_q); end
      default: ;
    endcase
  end
  assign prod = ma * mb;

  // CORDIC angle: heading + d/2 in Q2.30, loaded while d is formed, then
  // brought below 2*pi in magnitude by subtracting 2*pi * 2^k toward zero,
  // one k per cycle from RedSteps-1 down to 0, and folded.
  logic signed [31:0] th_w;
  logic signed [31:0] d_w;
  logic signed [63:0] ang_w;
  logic signed [47:0] zr_q, red_k, zr_next;
  logic signed [35:0] z0, zf;
  logic neg_w;
  logic neg_q;
  assign d_w   = ddo_pkg::sat32(64'(prod >>> 8));
  assign ang_w = 64'(hd_q) + 64'(d_w >>> 1);
  assign red_k = 48'(ddo_pkg::TwoPiQ30) <<< step_q;

  always_comb begin
    zr_next = zr_q;
    if (zr_q >= red_k) zr_next = zr_q - red_k;
    else if (zr_q <= -red_k) zr_next = zr_q + red_k;
  end

  always_comb begin
    z0 = zr_q[35:0];
    if (z0 > ddo_pkg::PiQ30) z0 = z0 - ddo_pkg::TwoPiQ30;
    if (z0 < -ddo_pkg::PiQ30) z0 = z0 + ddo_pkg::TwoPiQ30;
    neg_w = 1'b0;
    zf = z0;
    if (z0 > ddo_pkg::HalfPiQ30) begin
      zf = z0 - ddo_pkg::PiQ30;
      neg_w = 1'b1;
    end else if (z0 < -ddo_pkg::HalfPiQ30) begin
      zf = z0 + ddo_pkg::PiQ30;
      neg_w = 1'b1;
    end
  end

  ddo_pkg::cordic_ctl_t cctl;
  logic signed [33:0] c_raw, s_raw;
  assign cctl.start = (state_q == StLoad);
  assign cctl.run   = (state_q == StRot);
  assign cctl.step  = step_q;

  ddo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .z_i    (zf),
    .cos_o  (c_raw),
    .sin_o  (s_raw)
  );
  assign cos_w = neg_q ? -c_raw : c_raw;
  assign sin_w = neg_q ? -s_raw : s_raw;

  assign th_w = ddo_pkg::sat32(64'(hd_q) + 64'(d_q));

  // Sequencer decision on the new heading and edge distance.
  logic signed [31:0] ed_new;
  assign ed_new = ddo_pkg::sat32(64'(ed_q) + 64'(s_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      step_q       <= '0;
      last_r_q     <= '0;
      last_l_q     <= '0;
      px_q         <= '0;
      py_q         <= '0;
      hd_q         <= '0;
      ed_q         <= '0;
      tt_q         <= '0;
      turning_q    <= 1'b0;
      short_next_q <= 1'b0;
      cnt_q        <= '0;
      move_q       <= ddo_pkg::MoveStop;
      neg_q        <= 1'b0;
      rs_q         <= '0;
      ls_q         <= '0;
      d_q          <= '0;
      s_q          <= '0;
      zr_q         <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StRight;
        StRight: begin
          rs_q     <= ddo_pkg::sat32(64'(prod >>> (32 - ddo_pkg::FracBits)));
          last_r_q <= in_r_q;
          state_q  <= StLeft;
        end
        StLeft: begin
          ls_q     <= ddo_pkg::sat32(64'(prod >>> (32 - ddo_pkg::FracBits)));
          last_l_q <= in_l_q;
          state_q  <= StHead;
        end
        StHead: begin
          d_q     <= d_w;
          s_q     <= (33'(rs_q) + 33'(ls_q)) >>> 1;
          zr_q    <= 48'(ang_w <<< (30 - ddo_pkg::FracBits));
          step_q  <= ddo_pkg::StepW'(ddo_pkg::RedSteps - 1);
          state_q <= StRed;
        end
        StRed: begin
          zr_q <= zr_next;
          if (step_q == '0) state_q <= StLoad;
          else step_q <= step_q - 1'b1;
        end
        StLoad: begin
          // Hold the fold sign of the angle that the CORDIC loads now.
          neg_q   <= neg_w;
          step_q  <= '0;
          state_q <= StRot;
        end
        StRot: begin
          if (step_q == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1)) state_q <= StPosX;
          else step_q <= step_q + 1'b1;
        end
        StPosX: begin
          px_q    <= ddo_pkg::sat32(64'(px_q) + 64'(prod >>> 30));
          state_q <= StPosY;
        end
        StPosY: begin
          logic [1:0] mv;
          py_q <= ddo_pkg::sat32(64'(py_q) + 64'(prod >>> 30));
          hd_q <= th_w;
          mv = ddo_pkg::MoveForward;
          if (turning_q) begin
            if (th_w >= tt_q) turning_q <= 1'b0;
            else mv = ddo_pkg::MoveTurn;
          end else begin
            if (ed_new >= $signed({1'b0, short_q}) && short_next_q) begin
              ed_q <= '0; turning_q <= 1'b1; short_next_q <= 1'b0;
              if (cnt_q != 4'd15) cnt_q <= cnt_q + 1'b1;
              tt_q <= ddo_pkg::sat32(64'(th_w) + 64'(turn_ang_q));
              mv = ddo_pkg::MoveTurn;
            end else if (ed_new >= $signed({1'b0, long_q})) begin
              ed_q <= '0; turning_q <= 1'b1; short_next_q <= 1'b1;
              if (cnt_q != 4'd15) cnt_q <= cnt_q + 1'b1;
              tt_q <= ddo_pkg::sat32(64'(th_w) + 64'(turn_ang_q));
              mv = ddo_pkg::MoveTurn;
            end else begin
              ed_q <= ed_new;
            end
          end
          move_q  <= mv;
          state_q <= StOut;
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      in_r_q <= right_ticks_i;
      in_l_q <= left_ticks_i;
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = (state_q == StOut);
  assign move_code_o     = (cnt_q >= limit_q) ? ddo_pkg::MoveStop : move_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign heading_out_o   = hd_q;
  assign edges_done_o    = cnt_q;
  assign edge_progress_o = ed_q[31] ? 31'd0 : ed_q[30:0];

  `DDO_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "ready while result pending")
  `DDO_ASSERT(a_out_holds, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `DDO_ASSERT(a_cnt_sat, (cnt_q == 4'd15) |=> (cnt_q == 4'd15), "edge count wrapped")
endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the odometry and edge sequencer core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  // One wheel-count beat and one expected pose/move beat.
  typedef struct packed {
    logic signed [31:0] right;
    logic signed [31:0] left;
  } ticks_t;

  typedef struct packed {
    logic [1:0]         move;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hdg;
    logic [3:0]         edges;
    logic [30:0]        prog;
  } pose_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] right_ticks_i = '0;
  logic signed [31:0] left_ticks_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         move_code_o;
  logic signed [31:0] pos_x_o, pos_y_o, heading_out_o;
  logic [3:0]         edges_done_o;
  logic [30:0]        edge_progress_o;

  always #2 clk_i = ~clk_i;

  diff_drive_odometry_sequencer_core dut (.*);

  // Predictor state: configuration and odometry/sequencer state.
  logic [23:0] mpt;
  logic [15:0] inv_track;
  logic [30:0] short_len, long_len, turn_gain;
  logic [3:0]  lim;
  logic [31:0] prev_r, prev_l;
  longint      px, py, hd, edist, target;
  bit          turning, short_due;
  int          edge_cnt;

  ticks_t pending_ticks[$];
  pose_t  expected_poses[$];
  bit     quiet = 1'b0;   // no idling in the final stretch
  bit     failed = 1'b0;
  int     send_gap = 0, take_gap = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wheel_travel(logic [31:0] now, logic [31:0] prev);
    logic [31:0] diff;
    longint      d;
    diff = now - prev;
    d = longint'(signed'(diff));
    return clamp32(floor_shr(d * longint'(mpt), 32 - ddo_pkg::FracBits));
  endfunction

  // Shift-and-add rotation of the gain vector; returns cosine and sine in Q2.30.
  task automatic rotate(input longint ang, output longint c, output longint s);
    longint z, x, y, nx, at;
    bit     flip;
    z = (ang * (longint'(1) << (30 - ddo_pkg::FracBits))) % longint'(ddo_pkg::TwoPiQ30);
    x = longint'(ddo_pkg::GainQ30);
    y = 0;
    flip = 1'b0;
    if (z > longint'(ddo_pkg::PiQ30)) z -= longint'(ddo_pkg::TwoPiQ30);
    if (z < -longint'(ddo_pkg::PiQ30)) z += longint'(ddo_pkg::TwoPiQ30);
    if (z > longint'(ddo_pkg::HalfPiQ30)) begin
      z -= longint'(ddo_pkg::PiQ30); flip = 1'b1;
    end else if (z < -longint'(ddo_pkg::HalfPiQ30)) begin
      z += longint'(ddo_pkg::PiQ30); flip = 1'b1;
    end
    for (int i = 0; i < ddo_pkg::CordicSteps && i < 31; i++) begin
      case (i)
        0: at = 843314857; 1: at = 497837829; 2: at = 263043837;
        3: at = 133525159; 4: at = 67021687;  5: at = 33543516;
        6: at = 16775851;  7: at = 8388437;   8: at = 4194283;
        9: at = 2097149;
        default: at = longint'(1) << (30 - i);
      endcase
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= at;
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += at;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input ticks_t t);
    longint rs, ls, fwd, dh, c, sn, nx, ny, th;
    pose_t  p;
    rs = wheel_travel(t.right, prev_r); prev_r = t.right;
    ls = wheel_travel(t.left, prev_l);  prev_l = t.left;
    fwd = floor_shr(rs + ls, 1);
    dh = clamp32(floor_shr((rs - ls) * longint'(inv_track), 8));
    rotate(hd + floor_shr(dh, 1), c, sn);
    nx = clamp32(px + floor_shr(c * fwd, 30));
    ny = clamp32(py + floor_shr(sn * fwd, 30));
    th = clamp32(hd + dh);
    if (turning) begin
      if (th >= target) begin
        turning = 1'b0; p.move = ddo_pkg::MoveForward;
      end else p.move = ddo_pkg::MoveTurn;
    end else begin
      edist = clamp32(edist + fwd);
      if (edist >= longint'(short_len) && short_due) begin
        edist = 0; turning = 1'b1; short_due = 1'b0;
        if (edge_cnt < 15) edge_cnt++;
        target = clamp32(th + longint'(turn_gain)); p.move = ddo_pkg::MoveTurn;
      end else if (edist >= longint'(long_len)) begin
        edist = 0; turning = 1'b1; short_due = 1'b1;
        if (edge_cnt < 15) edge_cnt++;
        target = clamp32(th + longint'(turn_gain)); p.move = ddo_pkg::MoveTurn;
      end else p.move = ddo_pkg::MoveForward;
    end
    hd = th; px = nx; py = ny;
    if (edge_cnt >= lim) p.move = ddo_pkg::MoveStop;
    p.x = px[31:0]; p.y = py[31:0]; p.hdg = hd[31:0];
    p.edges = edge_cnt[3:0];
    p.prog = (edist < 0) ? '0 : edist[30:0];
    expected_poses.push_back(p);
  endtask

  // Driver: hold the beat until accepted, idle in random bursts.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_pose({right_ticks_i, left_ticks_i});
    end
    if (in_valid_i && !in_ready_o) begin
      // hold
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(0, 8);
      in_valid_i <= 1'b0;
    end else if (pending_ticks.size() > 0) begin
      ticks_t t;
      t = pending_ticks.pop_front();
      right_ticks_i <= t.right;
      left_ticks_i <= t.left;
      in_valid_i <= 1'b1;
    end else in_valid_i <= 1'b0;
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        $error("unexpected result beat");
        failed = 1'b1;
      end else begin
        pose_t e;
        e = expected_poses.pop_front();
        if (move_code_o !== e.move) begin
          $error("move_code exp %0d got %0d", e.move, move_code_o); failed = 1'b1;
        end
        if (pos_x_o !== e.x) begin
          $error("pos_x exp %0d got %0d", e.x, pos_x_o); failed = 1'b1;
        end
        if (pos_y_o !== e.y) begin
          $error("pos_y exp %0d got %0d", e.y, pos_y_o); failed = 1'b1;
        end
        if (heading_out_o !== e.hdg) begin
          $error("heading_out exp %0d got %0d", e.hdg, heading_out_o); failed = 1'b1;
        end
        if (edges_done_o !== e.edges) begin
          $error("edges_done exp %0d got %0d", e.edges, edges_done_o); failed = 1'b1;
        end
        if (edge_progress_o !== e.prog) begin
          $error("edge_progress exp %0d got %0d", e.prog, edge_progress_o);
          failed = 1'b1;
        end
      end
    end
    if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      take_gap <= $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val[30:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ddo_pkg::CfgMpt:   mpt = val[23:0];
      ddo_pkg::CfgInvTr: inv_track = val[15:0];
      ddo_pkg::CfgShort: short_len = val[30:0];
      ddo_pkg::CfgLong:  long_len = val[30:0];
      ddo_pkg::CfgTurn:  turn_gain = val[30:0];
      ddo_pkg::CfgLimit: lim = val[3:0];
      default: ;
    endcase
  endtask

  // Wait for the core to drain completely before touching registers.
  task automatic drain();
    wait (pending_ticks.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && expected_poses.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  logic [31:0] cur_r, cur_l;

  // Queue a run of counts that drive forward (both wheels), backward or on the right wheel only, with random jumps.
  task automatic add_drive(input int n, input int step_hi);
    ticks_t t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin cur_r = $urandom; cur_l = $urandom; end
        1: begin cur_r -= $urandom_range(0, step_hi); cur_l -= $urandom_range(0, step_hi); end
        2: cur_r += $urandom_range(0, step_hi);
        default: begin
          cur_r += $urandom_range(0, step_hi);
          cur_l += $urandom_range(0, step_hi);
        end
      endcase
      t.right = cur_r; t.left = cur_l;
      pending_ticks.push_back(t);
    end
  endtask

  task automatic push_ticks(input logic [31:0] r, input logic [31:0] l);
    ticks_t t;
    t.right = r; t.left = l; cur_r = r; cur_l = l;
    pending_ticks.push_back(t);
  endtask

  initial begin
    mpt = 899079; inv_track = 6400; short_len = 39951; long_len = 59927;
    turn_gain = 65536; lim = 12;
    prev_r = 0; prev_l = 0; px = 0; py = 0; hd = 0; edist = 0; target = 0;
    turning = 0; short_due = 0; edge_cnt = 0; cur_r = 0; cur_l = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero motion, extremes, wrap of the count, backward, spin in place.
    push_ticks(0, 0);
    push_ticks(32'h7fffffff, 32'h7fffffff);
    push_ticks(32'h80000000, 32'h80000000);
    push_ticks(32'hffffffff, 32'h00000000);
    push_ticks(32'h00000000, 32'hffffffff);
    push_ticks(32'h7fffffff, 32'h80000000);
    push_ticks(32'h80000000, 32'h7fffffff);
    push_ticks(32'h80000100, 32'h7fffff00);
    push_ticks(32'h80000000, 32'h80000000);
    for (int i = 0; i < 12; i++) push_ticks(cur_r + 200, cur_l + 200 + i * 30);
    drain();

    // Extreme settings: zero edge lengths and turn angle, and an edge limit of one.
    write_reg(ddo_pkg::CfgShort, 0); write_reg(ddo_pkg::CfgLong, 0);
    write_reg(ddo_pkg::CfgTurn, 0);
    write_reg(ddo_pkg::CfgLimit, 1);
    add_drive(40, 300);
    drain();

    write_reg(ddo_pkg::CfgMpt, 32'h00ffffff); write_reg(ddo_pkg::CfgInvTr, 32'h0000ffff);
    write_reg(ddo_pkg::CfgShort, 32'h7fffffff); write_reg(ddo_pkg::CfgLong, 32'h7fffffff);
    write_reg(ddo_pkg::CfgTurn, 32'h7fffffff); write_reg(ddo_pkg::CfgLimit, 15);
    add_drive(60, 32'hffffffff);
    drain();

    write_reg(ddo_pkg::CfgMpt, 1); write_reg(ddo_pkg::CfgInvTr, 1);
    add_drive(40, 32'hffffffff);
    drain();

    // Square-drive phases with random but sane settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ddo_pkg::CfgMpt, $urandom_range(100000, 2000000));
      write_reg(ddo_pkg::CfgInvTr, $urandom_range(1000, 20000));
      write_reg(ddo_pkg::CfgShort, $urandom_range(2000, 40000));
      write_reg(ddo_pkg::CfgLong, $urandom_range(2000, 60000));
      write_reg(ddo_pkg::CfgTurn, $urandom_range(5000, 80000));
      write_reg(ddo_pkg::CfgLimit, $urandom_range(1, 15));
      if (ph == 7) quiet = 1'b1;
      add_drive(120, 400);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
